/* design/integer_field_formatter_core_assert.svh */
// integer_field_formatter_core_assert.svh: assertion macros for the formatter checkers
// depends on: nothing; the user supplies clk and rst in its scope
`ifndef INTEGER_FIELD_FORMATTER_CORE_ASSERT_SVH
`define INTEGER_FIELD_FORMATTER_CORE_ASSERT_SVH

// clocked assertion, off while reset is high
`define IFFMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define IFFMT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/iffmt_pkg.sv */
// iffmt_pkg: types, codes and helpers for the integer field formatter
// depends on: nothing
package iffmt_pkg;

  localparam int DEF_MAX_WIDTH = 60;
  localparam int BCD_DIGITS    = 20;
  localparam int BCD_W         = 4 * BCD_DIGITS;
  localparam int NUM_DIGITS    = 22;
  localparam int DIG_W         = 4 * NUM_DIGITS;

  localparam logic [2:0] MODE_SDEC = 3'd0;
  localparam logic [2:0] MODE_UDEC = 3'd1;
  localparam logic [2:0] MODE_OCT  = 3'd2;
  localparam logic [2:0] MODE_LHEX = 3'd3;
  localparam logic [2:0] MODE_UHEX = 3'd4;
  localparam logic [2:0] MODE_PTR  = 3'd5;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LA    = 8'h61;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] value;
    logic        wide;
    logic [5:0]  field_width;
    logic        zero_pad;
    logic        plus_flag;
  } req_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } chr_t;

  typedef struct packed {
    logic start;
    logic wide;
  } dd_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CONV, ST_SIZE, ST_SIGN, ST_PFX0, ST_PFX1, ST_PAD, ST_DIGIT
  } state_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] res;
    if (d < 4'd10) begin
      res = CH_ZERO + {4'd0, d};
    end else begin
      res = (upper ? CH_UA : CH_LA) + {4'd0, d} - 8'd10;
    end
    return res;
  endfunction

endpackage

/* design/iffmt_dabble.sv */
// iffmt_dabble: shift-and-add-3 binary to bcd converter, one bit per cycle
// depends on: iffmt_pkg
module iffmt_dabble (
  input  logic                       clk,
  input  logic                       rst,
  input  iffmt_pkg::dd_ctrl_t        ctrl,
  input  logic [63:0]                value,
  output logic                       busy,
  output logic [iffmt_pkg::BCD_W-1:0] bcd
);
  import iffmt_pkg::*;

  logic [63:0]      bin;
  logic [6:0]       cnt;
  logic [BCD_W-1:0] adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    adj = bcd;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ctrl.start) begin
      busy <= 1'b1;
    end else if (busy && cnt == 7'd1) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      bin <= ctrl.wide ? value : {value[31:0], 32'd0};
      bcd <= '0;
      cnt <= ctrl.wide ? 7'd64 : 7'd32;
    end else if (busy) begin
      bcd <= {adj[BCD_W-2:0], bin[63]};
      bin <= {bin[62:0], 1'b0};
      cnt <= cnt - 7'd1;
    end
  end

endmodule

/* design/integer_field_formatter_core.sv */
// integer_field_formatter_core: printf-style integer field formatter, one char per transfer
// depends on: iffmt_pkg, iffmt_dabble
//
//   channel | dir | payload        | handshake
//   req     | in  | iffmt_pkg::req_t | req_valid / req_stall
//   chr     | out | iffmt_pkg::chr_t | chr_valid / chr_stall
//
// decimal request: the bit-serial bcd converter takes in all 64 bits wide or 32 narrow,
//   then sizing runs; then one char per cycle while chr_stall is low
// octal, hex and pointer requests skip the converter and go straight to sizing; digits are bit slices
// a field has up to 61 chars; one request at a time, req_stall high until the last
//   char sits in the output register
// rst is synchronous and returns the sequencer to idle with no char pending
// chr_stall holds the output register and freezes the sequencer in its emit state
module integer_field_formatter_core #(
  parameter int MAX_WIDTH = iffmt_pkg::DEF_MAX_WIDTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  iffmt_pkg::req_t req,
  output logic            chr_valid,
  input  logic            chr_stall,
  output iffmt_pkg::chr_t chr
);
  import iffmt_pkg::*;

  state_t state, state_next;

  // request decode
  logic        accept;
  logic        valid_mode;
  logic        is_dec;
  logic        neg;
  logic [63:0] v_in;
  logic [63:0] mag;
  logic [DIG_W-1:0] slice_digs;

  // latched request attributes
  logic             upper;
  logic             is_ptr;
  logic             has_sign;
  logic [7:0]       sign_char;
  logic [7:0]       pad_char;
  logic [5:0]       width;
  logic [DIG_W-1:0] digs;
  logic [5:0]       padcnt;
  logic [4:0]       idx;

  // sizing
  logic [4:0] nd;
  logic [5:0] pad_calc;

  // emit side
  logic emit;
  logic free;
  logic go;
  chr_t ch;

  // converter link
  dd_ctrl_t             dd_ctrl;
  logic                 dd_busy;
  logic [BCD_W-1:0]     dd_bcd;

  assign req_stall  = (state != ST_IDLE);
  assign accept     = req_valid && !req_stall;
  assign valid_mode = (req.mode <= MODE_PTR);
  assign is_dec     = (req.mode == MODE_SDEC) || (req.mode == MODE_UDEC);

  // narrow arguments are the low 32 bits, sign taken from bit 31
  assign v_in = req.wide ? req.value : {32'd0, req.value[31:0]};
  assign neg  = (req.mode == MODE_SDEC) && (req.wide ? req.value[63] : req.value[31]);
  assign mag  = !neg ? v_in :
                req.wide ? (64'd0 - req.value) : {32'd0, 32'd0 - req.value[31:0]};

  // octal and hex digits are plain slices of the magnitude
  always_comb begin
    slice_digs = '0;
    if (req.mode == MODE_OCT) begin
      for (int i = 0; i < NUM_DIGITS - 1; i++) begin
        slice_digs[4*i +: 4] = {1'b0, mag[3*i +: 3]};
      end
      slice_digs[4*(NUM_DIGITS-1) +: 4] = {3'd0, mag[63]};
    end else begin
      slice_digs[63:0] = mag;
    end
  end

  assign dd_ctrl.start = accept && is_dec;
  assign dd_ctrl.wide  = req.wide;

  iffmt_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (dd_ctrl),
    .value (mag),
    .busy  (dd_busy),
    .bcd   (dd_bcd)
  );

  // digit count: highest nonzero digit, at least one digit
  always_comb begin
    nd = 5'd1;
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (digs[4*i +: 4] != 4'd0) begin
        nd = 5'(i + 1);
      end
    end
    pad_calc = (width > {1'b0, nd}) ? (width - {1'b0, nd}) : 6'd0;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && valid_mode) begin
          state_next = is_dec ? ST_CONV : ST_SIZE;
        end
      end
      ST_CONV: begin
        if (!dd_busy) begin
          state_next = ST_SIZE;
        end
      end
      ST_SIZE: begin
        if (has_sign) begin
          state_next = ST_SIGN;
        end else if (is_ptr) begin
          state_next = ST_PFX0;
        end else if (pad_calc != 6'd0) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_DIGIT;
        end
      end
      ST_SIGN, ST_PFX1: begin
        if (go) begin
          state_next = (padcnt != 6'd0) ? ST_PAD : ST_DIGIT;
        end
      end
      ST_PFX0: begin
        if (go) begin
          state_next = ST_PFX1;
        end
      end
      ST_PAD: begin
        if (go && padcnt == 6'd1) begin
          state_next = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (go && idx == 5'd0) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // char produced by the current state
  always_comb begin
    emit        = 1'b0;
    ch.out_char = CH_ZERO;
    ch.last     = 1'b0;
    unique case (state)
      ST_IDLE, ST_CONV, ST_SIZE: begin
        emit = 1'b0;
      end
      ST_SIGN: begin
        emit        = 1'b1;
        ch.out_char = sign_char;
      end
      ST_PFX0: begin
        emit        = 1'b1;
        ch.out_char = CH_ZERO;
      end
      ST_PFX1: begin
        emit        = 1'b1;
        ch.out_char = CH_X;
      end
      ST_PAD: begin
        emit        = 1'b1;
        ch.out_char = pad_char;
      end
      ST_DIGIT: begin
        emit        = 1'b1;
        ch.out_char = digit_char(digs[4*idx +: 4], upper);
        ch.last     = (idx == 5'd0);
      end
    endcase
  end

  // output register frees up when empty or when its char transfers
  assign free = !chr_valid || !chr_stall;
  assign go   = emit && free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chr_valid <= 1'b0;
    end else if (go) begin
      chr_valid <= 1'b1;
    end else if (!chr_stall) begin
      chr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      chr <= ch;
    end
  end

  // request attributes and digit buffer
  always_ff @(posedge clk) begin
    if (accept) begin
      upper     <= (req.mode >= MODE_UHEX);
      is_ptr    <= (req.mode == MODE_PTR);
      has_sign  <= neg || (req.mode == MODE_SDEC && req.plus_flag);
      sign_char <= neg ? CH_MINUS : CH_PLUS;
      if (req.mode == MODE_PTR) begin
        width    <= req.wide ? 6'd16 : 6'd8;
        pad_char <= CH_ZERO;
      end else begin
        width    <= (req.field_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : req.field_width;
        pad_char <= req.zero_pad ? CH_ZERO : CH_SPACE;
      end
      digs <= slice_digs;
    end else if (state == ST_CONV && !dd_busy) begin
      digs <= {{(DIG_W-BCD_W){1'b0}}, dd_bcd};
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SIZE) begin
      padcnt <= pad_calc;
      idx    <= nd - 5'd1;
    end else begin
      if (state == ST_PAD && go) begin
        padcnt <= padcnt - 6'd1;
      end
      if (state == ST_DIGIT && go) begin
        idx <= idx - 5'd1;
      end
    end
  end

endmodule

/* design/iffmt_checker.sv */
// iffmt_checker: port-level checks on the integer field formatter, bound to the top level
// depends on: iffmt_pkg, integer_field_formatter_core_assert.svh
`include "integer_field_formatter_core_assert.svh"

module iffmt_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_stall,
  input iffmt_pkg::req_t req,
  input logic            chr_valid,
  input logic            chr_stall,
  input iffmt_pkg::chr_t chr
);
  import iffmt_pkg::*;

  // a stalled char stays put
  `IFFMT_ASSERT(a_chr_hold, chr_valid && chr_stall |=> chr_valid && $stable(chr), "stalled char changed")

  // a known conversion keeps the block busy the next cycle
  `IFFMT_ASSERT(a_busy_after_req, req_valid && !req_stall && req.mode <= MODE_PTR |=> req_stall, "not busy after request")

  // once idle again only the final char of a field may still wait
  `IFFMT_ASSERT(a_idle_last, chr_valid && !req_stall |-> chr.last, "idle with a field unfinished")

  // chars of one field follow each other with no gap
  `IFFMT_ASSERT(a_field_no_gap, chr_valid && !chr_stall && !chr.last |=> chr_valid, "gap inside a field")

endmodule

bind integer_field_formatter_core iffmt_checker u_iffmt_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .chr_valid (chr_valid),
  .chr_stall (chr_stall),
  .chr       (chr)
);
